// File: sv/pse_pkg.sv
// shared types and constants for the postfix stack evaluator
`timescale 1ns / 1ps

package pse_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_UNDERFLOW  = 3'd1;
	localparam logic [2:0] ST_OVERFLOW   = 3'd2;
	localparam logic [2:0] ST_BAD_SYMBOL = 3'd3;
	localparam logic [2:0] ST_EMPTY      = 3'd4;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_TIMES = 8'h2a;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
	} item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic        [2:0]  status;
	} result_t;

endpackage

// File: sv/postfix_stack_evaluator.sv
// postfix stack evaluator top level
`timescale 1ns / 1ps

// Evaluates postfix expressions one character per transaction: digits push 0..9, '+', '-'
// and '*' combine the two top operands with 32-bit wrapping arithmetic. A transaction with
// last set produces one result (top of stack and status) and clears the stack and the
// sticky status for the next expression. A new character may be accepted every cycle while
// item_ready is high; the top two operands live in registers and the deeper
// entries in a single-port-write memory whose top entry is kept prefetched in a register,
// so pushes and pops never wait on a memory read. A two-deep output buffer lets input
// flow on while a result waits; item_ready drops only when both output slots are full.
module postfix_stack_evaluator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  pse_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output pse_pkg::result_t result
);
	import pse_pkg::*;

	logic [31:0] mem [STACK_DEPTH];

	logic [LVL_W-1:0] level_q;
	logic [2:0]       sticky_q;
	logic [31:0]      top_q;
	logic [31:0]      next_q;
	logic [31:0]      rd_q;

	logic             skid_valid_q;
	result_t          skid_q;
	result_t          out_q;
	logic             out_valid_q;

	logic             fire;
	logic             is_digit;
	logic             is_op;
	logic             do_push;
	logic             do_pop;
	logic [2:0]       err;
	logic [2:0]       sticky_d;
	logic [LVL_W-1:0] level_d;
	logic [31:0]      top_d;
	logic [31:0]      op_res;
	logic [31:0]      digit_val;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic             push_res;
	result_t          new_res;

	assign fire      = item_valid && item_ready;
	assign is_digit  = (item.symbol >= CH_ZERO) && (item.symbol <= CH_NINE);
	assign is_op     = (item.symbol == CH_PLUS) || (item.symbol == CH_MINUS) ||
		(item.symbol == CH_TIMES);
	assign digit_val = {24'd0, item.symbol - CH_ZERO};
	assign do_push   = fire && is_digit && (level_q != LVL_W'(STACK_DEPTH));
	assign do_pop    = fire && is_op && (level_q >= LVL_W'(2));

	// address of the entry that gets spilled on a push, and of the entry below
	// the prefetched one that refills it on a pop
	assign wr_addr = ADDR_W'(level_q - LVL_W'(2));
	assign rd_addr = ADDR_W'(level_q - LVL_W'(4));

	always_comb begin
		unique case (item.symbol)
			CH_PLUS:  op_res = next_q + top_q;
			CH_MINUS: op_res = next_q - top_q;
			default:  op_res = next_q * top_q;
		endcase
	end

	always_comb begin
		err = ST_OK;
		if (is_digit) begin
			if (level_q == LVL_W'(STACK_DEPTH)) err = ST_OVERFLOW;
		end else if (is_op) begin
			if (level_q < LVL_W'(2)) err = ST_UNDERFLOW;
		end else begin
			err = ST_BAD_SYMBOL;
		end
		sticky_d = (sticky_q == ST_OK) ? err : sticky_q;

		level_d = level_q;
		top_d   = top_q;
		if (do_push) begin
			level_d = level_q + LVL_W'(1);
			top_d   = digit_val;
		end else if (do_pop) begin
			level_d = level_q - LVL_W'(1);
			top_d   = op_res;
		end

		new_res.value  = '0;
		new_res.status = sticky_d;
		if (sticky_d == ST_OK) begin
			if (level_d == '0) new_res.status = ST_EMPTY;
			else new_res.value = top_d;
		end
	end

	assign push_res = fire && item.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			sticky_q <= ST_OK;
		end else if (fire) begin
			if (item.last) begin
				level_q  <= '0;
				sticky_q <= ST_OK;
			end else begin
				level_q  <= level_d;
				sticky_q <= sticky_d;
			end
		end
	end

	// top two operands in registers, the rest in memory with its top prefetched in rd_q
	always_ff @(posedge clk) begin
		if (do_push) begin
			top_q  <= digit_val;
			next_q <= top_q;
			rd_q   <= next_q;
			if (level_q >= LVL_W'(2)) mem[wr_addr] <= next_q;
		end else if (do_pop) begin
			top_q  <= op_res;
			next_q <= rd_q;
			rd_q   <= mem[rd_addr];
		end
	end

	assign item_ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || result_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push_res;
			end else begin
				out_valid_q  <= push_res;
				skid_valid_q <= 1'b0;
			end
		end else if (push_res) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || result_ready) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= new_res;
			end else begin
				out_q  <= new_res;
			end
		end else if (push_res) begin
			skid_q <= new_res;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// File: verif/tb_postfix_stack_evaluator.sv
// testbench for the postfix stack evaluator: directed and random expressions, scored on the fly
`timescale 1ns / 1ps

module tb_postfix_stack_evaluator;

	import pse_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 16;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	// evaluator state mirrored in the testbench
	logic [31:0] operand_copy [STACK_DEPTH];
	int unsigned depth_copy;
	logic [2:0]  status_copy;

	result_t expected_results [$];
	int      mismatch_count = 0;
	int      cycle_count = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	int      hold_left = 0;

	postfix_stack_evaluator DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_postfix_stack_evaluator: FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic void latch_error(input logic [2:0] code);
		if (status_copy == ST_OK) status_copy = code;
	endfunction

	// applies one accepted character to the mirrored stack, queues a result on last
	function automatic void evaluate_symbol(input item_t it);
		logic [31:0] lhs;
		logic [31:0] rhs;
		logic [31:0] res;
		result_t     want;
		if (it.symbol >= CH_ZERO && it.symbol <= CH_NINE) begin
			if (depth_copy >= STACK_DEPTH) begin
				latch_error(ST_OVERFLOW);
			end else begin
				operand_copy[depth_copy] = {24'd0, it.symbol - CH_ZERO};
				depth_copy++;
			end
		end else if (it.symbol inside {CH_PLUS, CH_MINUS, CH_TIMES}) begin
			if (depth_copy < 2) begin
				latch_error(ST_UNDERFLOW);
			end else begin
				rhs = operand_copy[depth_copy - 1];
				lhs = operand_copy[depth_copy - 2];
				case (it.symbol)
					CH_PLUS:  res = lhs + rhs;
					CH_MINUS: res = lhs - rhs;
					default:  res = lhs * rhs;
				endcase
				depth_copy--;
				operand_copy[depth_copy - 1] = res;
			end
		end else begin
			latch_error(ST_BAD_SYMBOL);
		end
		if (it.last) begin
			want.status = status_copy;
			want.value  = '0;
			if (status_copy == ST_OK) begin
				if (depth_copy == 0) want.status = ST_EMPTY;
				else want.value = operand_copy[depth_copy - 1];
			end
			expected_results.push_back(want);
			depth_copy  = 0;
			status_copy = ST_OK;
		end
	endfunction

	// result side: scoring, random stalls and the long hold-off
	always @(posedge clk) begin : result_side
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result value %0d status %0d",
					result.value, result.status));
			end else begin
				want = expected_results.pop_front();
				if (result.value !== want.value)
					report_mismatch($sformatf("value got %0d want %0d",
						result.value, want.value));
				if (result.status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d",
						result.status, want.status));
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_symbol(input logic [7:0] sym, input logic is_last);
		item_t it;
		it = item_t'{symbol: sym, last: is_last};
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		evaluate_symbol(it);
	endtask

	task automatic send_text(input string text);
		for (int i = 0; i < text.len(); i++)
			send_symbol(text[i], i == text.len() - 1);
	endtask

	task automatic test_directed_ops();
		send_text("7");
		send_text("09-");
		send_text("99*8+");
		send_text("12");
		send_text("+");
		send_text("5*");
		send_symbol(8'h00, 1'b1);
		send_symbol(8'hff, 1'b1);
		// ':' sits just past '9', later characters still run but status stays
		send_text("1:2+");
		send_symbol(CH_PLUS, 1'b0);
		send_symbol(8'hff, 1'b0);
		send_symbol("1", 1'b1);
	endtask

	task automatic test_stack_limits();
		string text;
		text = "";
		for (int i = 0; i < STACK_DEPTH; i++) text = {text, "9"};
		for (int i = 0; i < STACK_DEPTH - 1; i++) begin
			if (i % 2) text = {text, "*"};
			else text = {text, "-"};
		end
		send_text(text);
		// full stack then one more digit
		text = "";
		for (int i = 0; i <= STACK_DEPTH; i++) text = {text, "3"};
		send_text(text);
		// full stack, one add, leftovers below the top
		text = "";
		for (int i = 0; i < STACK_DEPTH; i++) text = {text, "8"};
		send_text({text, "+"});
		// overflow first, then a bad symbol that must not replace it
		text = "";
		for (int i = 0; i <= STACK_DEPTH; i++) text = {text, "1"};
		send_text({text, "x+"});
		// product chain that wraps past 32 bits
		text = "9";
		for (int i = 0; i < 12; i++) text = {text, "9*"};
		send_text(text);
		send_text("09-9*9*9*9*9*9*9*9*9*9*");
	endtask

	task automatic build_expression(ref logic [7:0] expr [$]);
		int pushes;
		int keep;
		int depth;
		int pick;
		expr.delete();
		pushes = ($urandom_range(15) == 0) ? $urandom_range(20, STACK_DEPTH + 1)
			: $urandom_range(1, 6);
		keep  = ($urandom_range(9) == 0) ? $urandom_range(2, 3) : 1;
		depth = 0;
		while (pushes > 0 || depth > keep) begin
			if (depth >= 2 && (pushes == 0 || $urandom_range(1) == 1)) begin
				pick = $urandom_range(3);
				expr.push_back(pick == 2 ? CH_PLUS : pick == 3 ? CH_MINUS : CH_TIMES);
				depth--;
			end else begin
				expr.push_back(CH_ZERO + 8'($urandom_range(9)));
				pushes--;
				depth++;
			end
		end
	endtask

	task automatic test_random_expressions(input int item_budget, input int send_pct,
			input int stall_pct);
		logic [7:0] expr [$];
		int         sent;
		int         kind;
		sent           = 0;
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		while (sent < item_budget) begin
			kind = $urandom_range(99);
			if (kind < 90) begin
				build_expression(expr);
				// broken sequences: stray byte or a dropped character
				if (kind >= 75) begin
					if ($urandom_range(1) == 0 || expr.size() < 2)
						expr.insert($urandom_range(expr.size()), 8'($urandom_range(255)));
					else
						expr.delete($urandom_range(expr.size() - 1));
				end
			end else begin
				expr.delete();
				repeat ($urandom_range(1, 5)) expr.push_back(8'($urandom_range(255)));
			end
			foreach (expr[i]) send_symbol(expr[i], i == expr.size() - 1);
			sent += expr.size();
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 300;
		repeat (40) send_symbol(CH_ZERO + 8'($urandom_range(9)), 1'b1);
	endtask

	initial begin
		depth_copy  = 0;
		status_copy = ST_OK;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_ops();
		test_stack_limits();
		test_random_expressions(395, 0, 0);
		test_random_expressions(395, 80, 0);
		test_random_expressions(395, 0, 80);
		test_random_expressions(395, 7, 7);
		test_backpressure();

		item_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_postfix_stack_evaluator: PASS");
		else
			$display("tb_postfix_stack_evaluator: FAIL");
		$finish;
	end

endmodule

// File: sim.f
sv/pse_pkg.sv
sv/postfix_stack_evaluator.sv
verif/tb_postfix_stack_evaluator.sv
